### design/visual_steering_velocity_law_defines.svh
// ----------------------------------------------------------------------------
// Visual steering velocity law: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef VISUAL_STEERING_VELOCITY_LAW_DEFINES_SVH
`define VISUAL_STEERING_VELOCITY_LAW_DEFINES_SVH

// A condition that holds at every clock edge outside reset.
`define VSVL_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// An implication within the same cycle.
`define VSVL_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// An implication that lands in the next cycle.
`define VSVL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/vsvl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law: package
// Widths, register indexes, reset values and the result type.
// ----------------------------------------------------------------------------
package vsvl_pkg;

  localparam int COORD_BITS_DEF    = 12;
  localparam int VEL_FRAC_BITS_DEF = 12;

  localparam int VEL_W      = 16;  // velocity commands
  localparam int GAIN_W     = 16;  // Q8.8 gains and Q0.16 fraction
  localparam int STEER_W    = 15;  // deadband and limit
  localparam int QUO_W      = 16;  // quotient bits produced by each divider
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEER_GAIN      = 3'd0,
    REG_STEER_DEADBAND  = 3'd1,
    REG_STEER_LIMIT     = 3'd2,
    REG_TARGET_FRACTION = 3'd3,
    REG_ADVANCE_GAIN    = 3'd4,
    REG_ADVANCE_FLOOR   = 3'd5,
    REG_ADVANCE_CEILING = 3'd6
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0]        STEER_GAIN_RST      = 16'd256;
  localparam logic [STEER_W-1:0]       STEER_DEADBAND_RST  = 15'd205;
  localparam logic [STEER_W-1:0]       STEER_LIMIT_RST     = 15'd4096;
  localparam logic [GAIN_W-1:0]        TARGET_FRACTION_RST = 16'd9830;
  localparam logic [GAIN_W-1:0]        ADVANCE_GAIN_RST    = 16'd256;
  localparam logic signed [VEL_W-1:0]  ADVANCE_FLOOR_RST   = 16'sd0;
  localparam logic signed [VEL_W-1:0]  ADVANCE_CEILING_RST = 16'sd2048;

  typedef struct packed {
    logic signed [VEL_W-1:0] turn_rate;
    logic signed [VEL_W-1:0] advance_rate;
  } cmd_t;

endpackage

### design/vsvl_box_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law: box channel
// Carries one tracked box and the image size per item.
// ----------------------------------------------------------------------------
interface vsvl_box_if #(
  parameter int COORD_BITS = vsvl_pkg::COORD_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] box_left;
  logic [COORD_BITS:0]   box_span_x;
  logic [COORD_BITS:0]   box_span_y;
  logic [COORD_BITS:0]   frame_span_x;
  logic [COORD_BITS:0]   frame_span_y;

  modport source (
    output valid, box_left, box_span_x, box_span_y, frame_span_x, frame_span_y,
    input  ready
  );
  modport sink (
    input  valid, box_left, box_span_x, box_span_y, frame_span_x, frame_span_y,
    output ready
  );
endinterface

### design/vsvl_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law: command channel
// Carries the angular and linear velocity commands per item.
// ----------------------------------------------------------------------------
interface vsvl_cmd_if ();
  logic                              valid;
  logic                              ready;
  logic signed [vsvl_pkg::VEL_W-1:0] turn_rate;
  logic signed [vsvl_pkg::VEL_W-1:0] advance_rate;

  modport source (output valid, turn_rate, advance_rate, input ready);
  modport sink   (input valid, turn_rate, advance_rate, output ready);
endinterface

### design/vsvl_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law: configuration channel
// Register writes by index and data.
// ----------------------------------------------------------------------------
interface vsvl_cfg_if ();
  logic                                valid;
  logic                                ready;
  logic [vsvl_pkg::CFG_IDX_W-1:0]      index;
  logic [vsvl_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/vsvl_pipe_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law: pipelined restoring divider
// One quotient bit per register stage, with a sideband that travels along.
// ----------------------------------------------------------------------------
module vsvl_pipe_div #(
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem_init,
  input  logic [QUO_W-1:0]  num_low,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side_out
);

  // The remainder must start below the divisor. The low word shifts out at
  // the top while quotient bits shift in at the bottom, so after the last
  // stage it holds the quotient.
  logic              v_q    [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  lq_q   [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              v_s;
    logic [DEN_W-1:0]  rem_s;
    logic [QUO_W-1:0]  lq_s;
    logic [DEN_W-1:0]  den_s;
    logic [SIDE_W-1:0] side_s;
    logic [DEN_W:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_s    = in_valid;
      assign rem_s  = rem_init;
      assign lq_s   = num_low;
      assign den_s  = den;
      assign side_s = side_in;
    end else begin : g_next
      assign v_s    = v_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign lq_s   = lq_q[k-1];
      assign den_s  = den_q[k-1];
      assign side_s = side_q[k-1];
    end

    assign trial = {rem_s, lq_s[QUO_W-1]};
    assign ge    = trial >= {1'b0, den_s};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_s;
      end
      if (en) begin
        rem_q[k]  <= ge ? DEN_W'(trial - {1'b0, den_s}) : trial[DEN_W-1:0];
        lq_q[k]   <= {lq_s[QUO_W-2:0], ge};
        den_q[k]  <= den_s;
        side_q[k] <= side_s;
      end
    end
  end

  assign out_valid = v_q[QUO_W-1];
  assign quo       = lq_q[QUO_W-1];
  assign side_out  = side_q[QUO_W-1];

endmodule

### design/visual_steering_velocity_law.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law
// Proportional steering and approach law with deadband and clamp.
// ----------------------------------------------------------------------------
// One box item in gives one command item out, and a new box is taken every
// cycle while ready is high. Two 16-stage restoring dividers lie in series:
// the first pair divides the steering term by the image width and the box
// area by the image area side by side, the second divides the turn-scaled
// linear command by twice the steer limit. Seven short stages of offset,
// multiply and clamp logic and the output register lie along the path. An
// output register with a one-item skid stage sits at the end; ready drops
// only while that skid stage holds an item. Registers are written through
// the configuration channel, which is always ready, and should change only
// while no item is in flight.
`include "visual_steering_velocity_law_defines.svh"

module visual_steering_velocity_law #(
  parameter int COORD_BITS    = vsvl_pkg::COORD_BITS_DEF,
  parameter int VEL_FRAC_BITS = vsvl_pkg::VEL_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  vsvl_box_if.sink    box,
  vsvl_cmd_if.source  cmd,
  vsvl_cfg_if.sink    cfg
);

  localparam int SB     = COORD_BITS + 1;
  localparam int GW     = vsvl_pkg::GAIN_W;
  localparam int VW     = vsvl_pkg::VEL_W;
  localparam int SW     = vsvl_pkg::STEER_W;
  localparam int QW     = vsvl_pkg::QUO_W;
  localparam int ANG_SH = VEL_FRAC_BITS - 8;
  localparam int ANG_W  = GW + SB + ANG_SH;
  localparam int AREA_W = 2 * SB;
  localparam int LIN_SH = 24 - VEL_FRAC_BITS;
  localparam int LIN_W  = 2 * GW - LIN_SH;
  localparam int CL_W   = LIN_W + 1;

  // ---------------- configuration registers ----------------
  logic [GW-1:0]        steer_gain;
  logic [SW-1:0]        steer_deadband;
  logic [SW-1:0]        steer_limit;
  logic [GW-1:0]        target_fraction;
  logic [GW-1:0]        advance_gain;
  logic signed [VW-1:0] advance_floor;
  logic signed [VW-1:0] advance_ceiling;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain      <= vsvl_pkg::STEER_GAIN_RST;
      steer_deadband  <= vsvl_pkg::STEER_DEADBAND_RST;
      steer_limit     <= vsvl_pkg::STEER_LIMIT_RST;
      target_fraction <= vsvl_pkg::TARGET_FRACTION_RST;
      advance_gain    <= vsvl_pkg::ADVANCE_GAIN_RST;
      advance_floor   <= vsvl_pkg::ADVANCE_FLOOR_RST;
      advance_ceiling <= vsvl_pkg::ADVANCE_CEILING_RST;
    end else if (cfg.valid) begin
      case (vsvl_pkg::cfg_reg_t'(cfg.index))
        vsvl_pkg::REG_STEER_GAIN:      steer_gain      <= cfg.data[GW-1:0];
        vsvl_pkg::REG_STEER_DEADBAND:  steer_deadband  <= cfg.data[SW-1:0];
        vsvl_pkg::REG_STEER_LIMIT:     steer_limit     <= cfg.data[SW-1:0];
        vsvl_pkg::REG_TARGET_FRACTION: target_fraction <= cfg.data[GW-1:0];
        vsvl_pkg::REG_ADVANCE_GAIN:    advance_gain    <= cfg.data[GW-1:0];
        vsvl_pkg::REG_ADVANCE_FLOOR:   advance_floor   <= cfg.data[VW-1:0];
        vsvl_pkg::REG_ADVANCE_CEILING: advance_ceiling <= cfg.data[VW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic         enable;
  logic         o_valid;
  vsvl_pkg::cmd_t o_data;
  logic         skid_valid;
  vsvl_pkg::cmd_t skid_data;

  assign enable    = !skid_valid;
  assign box.ready = enable;

  // ---------------- stage 0: offset and frame fix-up ----------------
  logic [SB-1:0] fx_fix, fy_fix, half_fx, centre;

  assign fx_fix  = (box.frame_span_x == '0) ? SB'(1) : box.frame_span_x;
  assign fy_fix  = (box.frame_span_y == '0) ? SB'(1) : box.frame_span_y;
  assign half_fx = fx_fix >> 1;
  assign centre  = {1'b0, box.box_left} + (box.box_span_x >> 1);

  logic          p0_valid;
  logic          p0_neg;
  logic [SB-1:0] p0_absoff, p0_fx, p0_fy, p0_bx, p0_by;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (enable) begin
      p0_valid <= box.valid;
    end
    if (enable) begin
      p0_neg    <= centre > half_fx;
      p0_absoff <= (centre > half_fx) ? (centre - half_fx) : (half_fx - centre);
      p0_fx     <= fx_fix;
      p0_fy     <= fy_fix;
      p0_bx     <= box.box_span_x;
      p0_by     <= box.box_span_y;
    end
  end

  // ---------------- stage 1: products ----------------
  logic [GW+SB-1:0]  ang_prod;
  logic [ANG_W-1:0]  ang_ext;
  logic [AREA_W-1:0] area_num, area_den;

  assign ang_prod = steer_gain * p0_absoff;
  assign ang_ext  = ANG_W'(ang_prod);
  assign area_num = p0_bx * p0_by;
  assign area_den = p0_fx * p0_fy;

  logic              p1_valid;
  logic              p1_neg;
  logic [ANG_W-1:0]  p1_ang_num;
  logic [SB-1:0]     p1_fx;
  logic [AREA_W-1:0] p1_area_num, p1_area_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (enable) begin
      p1_valid <= p0_valid;
    end
    if (enable) begin
      p1_neg      <= p0_neg;
      p1_ang_num  <= ang_ext << ANG_SH;
      p1_fx       <= p0_fx;
      p1_area_num <= area_num;
      p1_area_den <= area_den;
    end
  end

  // ---------------- first dividers ----------------
  // A quotient of 2^16 or more is past every deadband and limit, and an area
  // fraction of one or more is past every target, so both only need 16 bits.
  logic          ang_sat, frac_sat;
  logic          ang_valid, frac_valid;
  logic [QW-1:0] ang_quo, frac_quo;
  logic [1:0]    ang_side;
  logic          frac_side;

  assign ang_sat  = p1_ang_num[ANG_W-1:QW] >= (ANG_W-QW)'(p1_fx);
  assign frac_sat = p1_area_num >= p1_area_den;

  vsvl_pipe_div #(.DEN_W(SB), .QUO_W(QW), .SIDE_W(2)) u_ang_div (
    .clk      (clk),
    .rst      (rst),
    .en       (enable),
    .in_valid (p1_valid),
    .rem_init (p1_ang_num[QW +: SB]),
    .num_low  (p1_ang_num[QW-1:0]),
    .den      (p1_fx),
    .side_in  ({p1_neg, ang_sat}),
    .out_valid(ang_valid),
    .quo      (ang_quo),
    .side_out (ang_side)
  );

  vsvl_pipe_div #(.DEN_W(AREA_W), .QUO_W(QW), .SIDE_W(1)) u_frac_div (
    .clk      (clk),
    .rst      (rst),
    .en       (enable),
    .in_valid (p1_valid),
    .rem_init (p1_area_num),
    .num_low  ('0),
    .den      (p1_area_den),
    .side_in  (frac_sat),
    .out_valid(frac_valid),
    .quo      (frac_quo),
    .side_out (frac_side)
  );

  // ---------------- stage 3: deadband, limit, size error ----------------
  logic [QW-1:0] mag_full;
  logic [SW-1:0] mag_sel;

  assign mag_full = ang_side[0] ? '1 : ang_quo;

  always_comb begin
    if (mag_full < {1'b0, steer_deadband}) begin
      mag_sel = '0;
    end else if (mag_full > {1'b0, steer_limit}) begin
      mag_sel = steer_limit;
    end else begin
      mag_sel = mag_full[SW-1:0];
    end
  end

  logic          p3_valid, p3_neg, p3_reached;
  logic [SW-1:0] p3_mag;
  logic [GW-1:0] p3_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      p3_valid <= 1'b0;
    end else if (enable) begin
      p3_valid <= ang_valid && frac_valid;
    end
    if (enable) begin
      p3_neg     <= ang_side[1];
      p3_mag     <= mag_sel;
      p3_reached <= frac_side || (frac_quo >= target_fraction);
      p3_diff    <= target_fraction - frac_quo;
    end
  end

  // ---------------- stage 4: linear gain ----------------
  logic            p4_valid, p4_neg, p4_reached;
  logic [SW-1:0]   p4_mag;
  logic [2*GW-1:0] p4_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      p4_valid <= 1'b0;
    end else if (enable) begin
      p4_valid <= p3_valid;
    end
    if (enable) begin
      p4_neg     <= p3_neg;
      p4_reached <= p3_reached;
      p4_mag     <= p3_mag;
      p4_prod    <= advance_gain * p3_diff;
    end
  end

  // ---------------- stage 5: clamp and turn sign ----------------
  logic signed [CL_W-1:0] lin_raw, ceil_x, floor_x, lin_c1, lin_c2;
  logic [VW-1:0]          turn_mag;

  assign lin_raw  = $signed({1'b0, p4_prod[2*GW-1:LIN_SH]});
  assign ceil_x   = CL_W'(advance_ceiling);
  assign floor_x  = CL_W'(advance_floor);
  assign lin_c1   = (lin_raw > ceil_x) ? ceil_x : lin_raw;
  assign lin_c2   = (lin_c1 < floor_x) ? floor_x : lin_c1;
  assign turn_mag = {1'b0, p4_mag};

  logic                 p5_valid;
  logic signed [VW-1:0] p5_lin, p5_turn;
  logic [SW-1:0]        p5_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      p5_valid <= 1'b0;
    end else if (enable) begin
      p5_valid <= p4_valid;
    end
    if (enable) begin
      p5_lin  <= p4_reached ? '0 : lin_c2[VW-1:0];
      p5_turn <= p4_neg ? (~turn_mag + 1'b1) : turn_mag;
      p5_mag  <= p4_mag;
    end
  end

  // ---------------- stage 6: turn scaling operands ----------------
  // A zero limit leaves the turn at zero and the scaling at one: use 1/1.
  logic          zero_limit;
  logic [VW-1:0] den_2l;

  assign zero_limit = steer_limit == '0;
  assign den_2l     = zero_limit ? VW'(1) : {steer_limit, 1'b0};

  logic                 p6_valid, p6_sign;
  logic [VW-1:0]        p6_abs, p6_factor, p6_den;
  logic signed [VW-1:0] p6_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      p6_valid <= 1'b0;
    end else if (enable) begin
      p6_valid <= p5_valid;
    end
    if (enable) begin
      p6_sign   <= p5_lin[VW-1];
      p6_abs    <= p5_lin[VW-1] ? (~p5_lin + 1'b1) : p5_lin;
      p6_factor <= zero_limit ? VW'(1) : (den_2l - {1'b0, p5_mag});
      p6_den    <= den_2l;
      p6_turn   <= p5_turn;
    end
  end

  // ---------------- stage 7: scaled product ----------------
  logic                 p7_valid, p7_sign;
  logic [2*VW-1:0]      p7_prod;
  logic [VW-1:0]        p7_den;
  logic signed [VW-1:0] p7_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      p7_valid <= 1'b0;
    end else if (enable) begin
      p7_valid <= p6_valid;
    end
    if (enable) begin
      p7_sign <= p6_sign;
      p7_prod <= p6_abs * p6_factor;
      p7_den  <= p6_den;
      p7_turn <= p6_turn;
    end
  end

  // ---------------- second divider ----------------
  // The product is below 2^16 times the divisor, so the high half starts
  // below it; the magnitude is divided so the result truncates toward zero.
  logic          scl_valid;
  logic [QW-1:0] scl_quo;
  logic [VW:0]   scl_side;

  vsvl_pipe_div #(.DEN_W(VW), .QUO_W(QW), .SIDE_W(VW+1)) u_scale_div (
    .clk      (clk),
    .rst      (rst),
    .en       (enable),
    .in_valid (p7_valid),
    .rem_init (p7_prod[2*VW-1:QW]),
    .num_low  (p7_prod[QW-1:0]),
    .den      (p7_den),
    .side_in  ({p7_sign, p7_turn}),
    .out_valid(scl_valid),
    .quo      (scl_quo),
    .side_out (scl_side)
  );

  // ---------------- output register and skid stage ----------------
  vsvl_pkg::cmd_t result;
  logic           push, o_free;

  assign result.turn_rate    = scl_side[VW-1:0];
  assign result.advance_rate = scl_side[VW] ? (~scl_quo + 1'b1) : scl_quo;
  assign push                = scl_valid && enable;
  assign o_free              = !o_valid || cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (o_free) begin
        o_valid    <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (o_free) begin
        o_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (cmd.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (o_free) begin
        o_data <= skid_data;
      end
    end else if (push) begin
      if (o_free) begin
        o_data <= result;
      end else begin
        skid_data <= result;
      end
    end
  end

  assign cmd.valid        = o_valid;
  assign cmd.turn_rate    = o_data.turn_rate;
  assign cmd.advance_rate = o_data.advance_rate;

  // ---------------- assertions ----------------
  `VSVL_ASSERT_IMPLY(a_skid_behind_out, skid_valid, o_valid, "skid item behind empty output")
  `VSVL_ASSERT_NOW(a_div_lockstep, ang_valid == frac_valid, "first dividers out of step")
  `VSVL_ASSERT_NEXT(a_skid_drains, skid_valid && cmd.ready, o_valid && !skid_valid, "skid stuck")

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Visual steering velocity law: testbench
// Drives tracked boxes through the steering law and checks every velocity
// command against a local prediction of the turn and advance laws. Register
// settings change only while no item is in flight. Both channels idle at
// random, with one phase that runs without any gaps or stalls.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB    = vsvl_pkg::COORD_BITS_DEF;
  localparam int SB    = CB + 1;
  localparam int VFRAC = vsvl_pkg::VEL_FRAC_BITS_DEF;
  localparam int VW    = vsvl_pkg::VEL_W;
  localparam int GW    = vsvl_pkg::GAIN_W;
  localparam int SW    = vsvl_pkg::STEER_W;
  localparam int IW    = vsvl_pkg::CFG_IDX_W;
  localparam logic [IW-1:0] CFG_SPARE_IDX = 3'd7;  // no register lives here
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_BOXES   = 230;

  typedef struct packed {
    logic [CB-1:0] left;
    logic [CB:0]   span_x;
    logic [CB:0]   span_y;
    logic [CB:0]   frame_x;
    logic [CB:0]   frame_y;
  } box_t;

  // Raw write data for all seven registers.
  typedef struct {
    logic [15:0] steer_gain;
    logic [15:0] steer_deadband;
    logic [15:0] steer_limit;
    logic [15:0] target_fraction;
    logic [15:0] advance_gain;
    logic [15:0] advance_floor;
    logic [15:0] advance_ceiling;
  } law_regs_t;

  logic clk;
  logic rst;
  bit   calm;

  int errors;
  int boxes_sent;
  int cmds_checked;
  int settings_applied;

  // Local copy of the register file, at the block's widths.
  logic [GW-1:0]        law_steer_gain;
  logic [SW-1:0]        law_deadband;
  logic [SW-1:0]        law_limit;
  logic [GW-1:0]        law_target;
  logic [GW-1:0]        law_advance_gain;
  logic signed [VW-1:0] law_floor;
  logic signed [VW-1:0] law_ceiling;

  vsvl_pkg::cmd_t pending_cmds[$];

  vsvl_box_if #(.COORD_BITS(CB)) box_ch ();
  vsvl_cmd_if cmd_ch ();
  vsvl_cfg_if cfg_ch ();

  visual_steering_velocity_law u_top (
    .clk (clk),
    .rst (rst),
    .box (box_ch),
    .cmd (cmd_ch),
    .cfg (cfg_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Expected command for one box under the current register values.
  function automatic vsvl_pkg::cmd_t steer_law(box_t b);
    longint fx, fy, bl, bx, by, offset, absoff, mag, frac, lin, adv, twol;
    longint gain, dead, lim, tgt, again, lo, hi;
    vsvl_pkg::cmd_t c;
    gain  = longint'(law_steer_gain);
    dead  = longint'(law_deadband);
    lim   = longint'(law_limit);
    tgt   = longint'(law_target);
    again = longint'(law_advance_gain);
    lo    = longint'(law_floor);
    hi    = longint'(law_ceiling);
    bl = longint'(b.left);
    bx = longint'(b.span_x);
    by = longint'(b.span_y);
    fx = longint'(b.frame_x);
    fy = longint'(b.frame_y);
    if (fx == 0) fx = 1;
    if (fy == 0) fy = 1;

    offset = fx / 2 - (bl + bx / 2);
    absoff = (offset < 0) ? -offset : offset;
    mag = ((gain * absoff) << (VFRAC - 8)) / fx;
    if (mag < dead) begin
      mag = 0;
    end else if (mag > lim) begin
      mag = lim;
    end
    c.turn_rate = VW'((offset < 0) ? -mag : mag);

    frac = ((bx * by) << 16) / (fx * fy);
    if (frac >= tgt) begin
      adv = 0;
    end else begin
      lin = (again * (tgt - frac)) >> (24 - VFRAC);
      if (lin > hi) lin = hi;
      if (lin < lo) lin = lo;
      if (lim == 0) begin
        adv = lin;
      end else begin
        // Signed division truncates toward zero, as the law requires.
        twol = 2 * lim;
        adv = (lin * (twol - mag)) / twol;
      end
    end
    c.advance_rate = VW'(adv);
    return c;
  endfunction

  function automatic box_t mk_box(int l, int bx, int by, int fx, int fy);
    box_t b;
    b.left    = CB'(l);
    b.span_x  = SB'(bx);
    b.span_y  = SB'(by);
    b.frame_x = SB'(fx);
    b.frame_y = SB'(fy);
    return b;
  endfunction

  function automatic int corner_span();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 1;
      2: return 4096;
      default: return 8191;
    endcase
  endfunction

  // Mostly boxes that lie inside a plausible frame; some noise and corners.
  function automatic box_t random_box();
    box_t b;
    int kind, fx, fy, bx, by, l;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      b = mk_box($urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (kind == 1) begin
      l = $urandom_range(0, 1) ? 4095 : 0;
      b = mk_box(l, corner_span(), corner_span(), corner_span(), corner_span());
    end else begin
      fx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
      fy = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 4096);
      bx = $urandom_range(0, 1) ? $urandom_range(0, fx) : $urandom_range(0, fx / 3);
      by = $urandom_range(0, 1) ? $urandom_range(0, fy) : $urandom_range(0, fy / 3);
      l  = $urandom_range(0, fx - bx);
      if (l > 4095) l = 4095;
      b = mk_box(l, bx, by, fx, fy);
    end
    return b;
  endfunction

  function automatic logic [15:0] spread(int lo, int hi, logic [15:0] ext_lo,
                                         logic [15:0] ext_hi);
    int typical;
    typical = lo + int'($urandom_range(0, hi - lo));
    case ($urandom_range(0, 7))
      0: return ext_lo;
      1: return ext_hi;
      default: return typical[15:0];
    endcase
  endfunction

  function automatic law_regs_t random_regs();
    law_regs_t s;
    s.steer_gain      = spread(0, 2048, 16'h0000, 16'hFFFF);
    s.steer_deadband  = spread(0, 600, 16'h0000, 16'hFFFF);
    s.steer_limit     = spread(256, 8192, 16'h0000, 16'h7FFF);
    s.target_fraction = spread(0, 30000, 16'h0000, 16'hFFFF);
    s.advance_gain    = spread(0, 2048, 16'h0000, 16'hFFFF);
    s.advance_floor   = spread(-4096, 0, 16'h8000, 16'h7FFF);
    s.advance_ceiling = spread(0, 8192, 16'h8000, 16'h7FFF);
    return s;
  endfunction

  // Commands are accepted whenever ready is high; calm phases never stall.
  initial begin
    cmd_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      cmd_ch.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  always @(posedge clk) begin : check_cmds
    vsvl_pkg::cmd_t want;
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      cmds_checked++;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command, expected none, got turn %0d advance %0d",
                 $time, cmd_ch.turn_rate, cmd_ch.advance_rate);
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (cmd_ch.turn_rate !== want.turn_rate) begin
          $display("%0t: turn_rate expected %0d, got %0d",
                   $time, want.turn_rate, cmd_ch.turn_rate);
          errors++;
        end
        if (cmd_ch.advance_rate !== want.advance_rate) begin
          $display("%0t: advance_rate expected %0d, got %0d",
                   $time, want.advance_rate, cmd_ch.advance_rate);
          errors++;
        end
      end
    end
  end

  // Leaves valid high on return; the next send or wait_idle takes it over.
  // Outside calm phases, a gap of random length, with valid low, goes before a
  // quarter of the items.
  task automatic send_box(input box_t b);
    if (!calm && $urandom_range(0, 99) < 25) begin
      box_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    box_ch.valid        <= 1'b1;
    box_ch.box_left     <= b.left;
    box_ch.box_span_x   <= b.span_x;
    box_ch.box_span_y   <= b.span_y;
    box_ch.frame_span_x <= b.frame_x;
    box_ch.frame_span_y <= b.frame_y;
    do @(posedge clk); while (!box_ch.ready);
    pending_cmds.insert(pending_cmds.size(), steer_law(b));
    boxes_sent++;
  endtask

  // Always waits on the clock before it returns, so the caller drives from a fresh
  // time step.
  task automatic wait_idle();
    box_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cmds.size() != 0);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      vsvl_pkg::REG_STEER_GAIN:      law_steer_gain   = val;
      vsvl_pkg::REG_STEER_DEADBAND:  law_deadband     = val[SW-1:0];
      vsvl_pkg::REG_STEER_LIMIT:     law_limit        = val[SW-1:0];
      vsvl_pkg::REG_TARGET_FRACTION: law_target       = val;
      vsvl_pkg::REG_ADVANCE_GAIN:    law_advance_gain = val;
      vsvl_pkg::REG_ADVANCE_FLOOR:   law_floor        = val;
      vsvl_pkg::REG_ADVANCE_CEILING: law_ceiling      = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input law_regs_t s, input bit with_spare);
    wait_idle();
    write_reg(vsvl_pkg::REG_STEER_GAIN, s.steer_gain);
    write_reg(vsvl_pkg::REG_STEER_DEADBAND, s.steer_deadband);
    write_reg(vsvl_pkg::REG_STEER_LIMIT, s.steer_limit);
    write_reg(vsvl_pkg::REG_TARGET_FRACTION, s.target_fraction);
    write_reg(vsvl_pkg::REG_ADVANCE_GAIN, s.advance_gain);
    write_reg(vsvl_pkg::REG_ADVANCE_FLOOR, s.advance_floor);
    write_reg(vsvl_pkg::REG_ADVANCE_CEILING, s.advance_ceiling);
    if (with_spare) write_reg(CFG_SPARE_IDX, 16'($urandom));
    cfg_ch.valid <= 1'b0;
    settings_applied++;
  endtask

  task automatic test_reset_values();
    send_box(mk_box(280, 80, 60, 640, 480));    // centered
    send_box(mk_box(0, 10, 10, 640, 480));      // far left of the image
    send_box(mk_box(630, 10, 10, 640, 480));    // far right of the image
    send_box(mk_box(0, 0, 0, 0, 0));            // zero frame size
    send_box(mk_box(5, 3, 2, 0, 0));
    send_box(mk_box(4095, 4096, 4096, 100, 100)); // box larger than the frame
    send_box(mk_box(4095, 8191, 8191, 8191, 8191));
    send_box(mk_box(0, 1, 1, 1, 1));
    wait_idle();
  endtask

  task automatic corner_boxes();
    send_box(mk_box(0, 40, 30, 640, 480));
    send_box(mk_box(600, 40, 30, 640, 480));
    send_box(mk_box(300, 200, 150, 640, 480));
    send_box(mk_box(2000, 4096, 1, 4096, 4096));
  endtask

  task automatic test_register_corners();
    // Every register at an extreme of its range, the deadband at zero.
    apply_setting('{16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF},
                  1'b0);
    corner_boxes();
    // Floor above ceiling, and a deadband wider than the limit.
    apply_setting('{16'd1024, 16'd8000, 16'd1000, 16'd30000, 16'd4096, 16'd500,
                    16'hFE0C}, 1'b0);
    corner_boxes();
    // A zero steer limit leaves the advance command unscaled.
    apply_setting('{16'd512, 16'd0, 16'd0, 16'd40000, 16'd2000, 16'hFF9C, 16'd4000},
                  1'b0);
    corner_boxes();
    // Mostly smallest values, but a full deadband; the target is always reached.
    apply_setting('{16'd0, 16'hFFFF, 16'd1, 16'd0, 16'd0, 16'h8000, 16'h8000}, 1'b0);
    corner_boxes();
    wait_idle();
  endtask

  task automatic test_sender_pause();
    apply_setting('{vsvl_pkg::STEER_GAIN_RST, 16'(vsvl_pkg::STEER_DEADBAND_RST),
                    16'(vsvl_pkg::STEER_LIMIT_RST), vsvl_pkg::TARGET_FRACTION_RST,
                    vsvl_pkg::ADVANCE_GAIN_RST, vsvl_pkg::ADVANCE_FLOOR_RST,
                    vsvl_pkg::ADVANCE_CEILING_RST}, 1'b0);
    repeat (20) send_box(random_box());
    // Hold the sender until the pipeline has emptied completely.
    wait_idle();
    repeat (20) send_box(random_box());
    wait_idle();
  endtask

  task automatic test_random_law();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      apply_setting(random_regs(), p == 3);
      calm = (p == 2);
      for (int i = 0; i < PHASE_BOXES; i++) begin
        send_box(random_box());
        if (p == 4 && i == PHASE_BOXES / 2) wait_idle();
      end
      wait_idle();
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    box_ch.valid = 1'b0;
    box_ch.box_left = '0;
    box_ch.box_span_x = '0;
    box_ch.box_span_y = '0;
    box_ch.frame_span_x = '0;
    box_ch.frame_span_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    law_steer_gain   = vsvl_pkg::STEER_GAIN_RST;
    law_deadband     = vsvl_pkg::STEER_DEADBAND_RST;
    law_limit        = vsvl_pkg::STEER_LIMIT_RST;
    law_target       = vsvl_pkg::TARGET_FRACTION_RST;
    law_advance_gain = vsvl_pkg::ADVANCE_GAIN_RST;
    law_floor        = vsvl_pkg::ADVANCE_FLOOR_RST;
    law_ceiling      = vsvl_pkg::ADVANCE_CEILING_RST;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_register_corners();
    test_sender_pause();
    test_random_law();

    wait_idle();
    repeat (48) @(posedge clk);
    $display("Checked %0d commands from %0d boxes under %0d register settings.",
             cmds_checked, boxes_sent, settings_applied);
    $display("Settings spanned extreme gains, zero limit, inverted clamps and wide deadbands.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Timed out with %0d commands still outstanding.", pending_cmds.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/vsvl_pkg.sv
design/vsvl_box_if.sv
design/vsvl_cmd_if.sv
design/vsvl_cfg_if.sv
design/vsvl_pipe_div.sv
design/visual_steering_velocity_law.sv
tb/tb_top.sv
